### src/fgtm_pkg.sv
// Shared types and constants of the filtered gesture template matcher.
package fgtm_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int DIST_W      = 15;
    localparam int SQRT_STEPS  = 15;
    localparam int DIV_STEPS   = 16;

    localparam logic [DIST_W-1:0] NO_MATCH_LIMIT = 15'd9999;
    localparam logic [DIST_W-1:0] DIST_MAX       = 15'h7FFF;

    localparam logic [7:0]  RST_FILTER_DIVISOR   = 8'd5;
    localparam logic [15:0] RST_STABLE_THRESHOLD = 16'd20;
    localparam logic [14:0] RST_IDLE_RELOAD      = 15'd100;
    localparam logic [5:0]  RST_TEMPLATE_COUNT   = 6'd32;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_TICK,
        CMD_LOAD_WORD,
        CMD_LOAD_RADIUS
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_DIVISOR,
        CFG_STABLE_THRESHOLD,
        CFG_IDLE_RELOAD,
        CFG_TEMPLATE_COUNT
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  filter_divisor;
        logic [15:0] stable_threshold;
        logic [14:0] idle_reload;
        logic [5:0]  template_count;
    } t_cfg;

    typedef struct packed {
        t_cmd               command;
        logic [2:0]         sensor_index;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [4:0]         template_index;
        logic [4:0]         element_index;
        logic signed [15:0] load_value;
    } t_item;

    typedef struct packed {
        logic        match_valid;
        logic [4:0]  match_index;
        logic [14:0] match_distance;
        logic        sleep_request;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_F_START,
        ST_F_DIV,
        ST_F_WR,
        ST_T_START,
        ST_T_ACC,
        ST_T_SQRT,
        ST_T_CMP,
        ST_DONE
    } t_state;

endpackage

### src/fgtm_fifo.sv
// Two-entry queue that decouples the command side from the engine and the engine from the reader.
module fgtm_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_din,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_dout,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         wr_ok;
    logic         rd_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_dout  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_ok) r_wp <= ~r_wp;
            if (rd_ok) r_rp <= ~r_rp;
            if (wr_ok && !rd_ok) r_cnt <= r_cnt + 2'd1;
            else if (rd_ok && !wr_ok) r_cnt <= r_cnt - 2'd1;
        end
    end

    // hold the beat
    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wp] <= i_din;
    end

endmodule

### src/fgtm_core.sv
// Engine: filter update, template scan, integer square root and result build.
module fgtm_core #(
    parameter int SENSORS            = 7,
    parameter int TEMPLATES          = 32,
    parameter int INITIAL_IDLE_TICKS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fgtm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [fgtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  fgtm_pkg::t_item               i_item,
    input  logic                          i_item_avail,
    output logic                          o_item_pop,
    output fgtm_pkg::t_result             o_res,
    output logic                          o_res_push,
    input  logic                          i_res_space
);

    localparam int VEC   = SENSORS * 3;
    localparam int VW    = $clog2(VEC);
    localparam int VCW   = $clog2(VEC + 1);
    localparam int TW    = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
    localparam int TCW   = $clog2(TEMPLATES + 1);
    localparam int AW    = $clog2(TEMPLATES * VEC);
    localparam int ACC_W = 32 + VCW;

    fgtm_pkg::t_state r_state, n_state;
    fgtm_pkg::t_cfg   r_cfg;
    fgtm_pkg::t_item  r_item;
    fgtm_pkg::t_result r_res;

    logic signed [15:0] r_vec [VEC];
    logic signed [15:0] r_tmem [TEMPLATES * VEC];
    logic signed [15:0] r_rmem [TEMPLATES];
    logic               r_first;
    logic [14:0]        r_idle;

    // filter path
    logic [1:0]         r_axis;
    logic [VW-1:0]      r_fidx;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic               r_neg;
    logic [15:0]        r_dq;
    logic [7:0]         r_drem;
    logic [3:0]         r_it;

    // scan path
    logic [TCW-1:0]     r_n;
    logic [TCW-1:0]     r_t;
    logic [AW-1:0]      r_base;
    logic [VCW-1:0]     r_ei;
    logic signed [15:0] r_rad;
    logic signed [15:0] r_tdat;
    logic signed [15:0] r_vq;
    logic               r_p1;
    logic               r_p2;
    logic [31:0]        r_sq;
    logic [ACC_W-1:0]   r_acc;
    logic [29:0]        r_sv;
    logic [16:0]        r_rem;
    logic [14:0]        r_root;
    logic               r_sat;
    logic [14:0]        r_best;
    logic               r_valid;
    logic [4:0]         r_bidx;

    logic               sensor_ok;
    logic [VW-1:0]      vec_ridx;
    logic signed [15:0] vec_rd;
    logic signed [15:0] axis_x;
    logic [7:0]         div;
    logic [8:0]         div_t9;
    logic               div_ge;
    logic signed [16:0] f_diff;
    logic signed [16:0] f_q;
    logic signed [16:0] f_ynew;
    logic signed [16:0] f_dev;
    logic [16:0]        f_dev_mag;
    logic signed [16:0] s_diff;
    logic [15:0]        s_mag;
    logic [17:0]        q_rem;
    logic [17:0]        q_trial;
    logic [14:0]        cand_dist;
    logic [18:0]        cmp_l;
    logic [18:0]        cmp_r;
    logic               hit;

    assign sensor_ok = 5'(r_item.sensor_index) < 5'(SENSORS);
    assign vec_ridx  = (r_state == fgtm_pkg::ST_T_ACC) ? r_ei[VW-1:0] : r_fidx;
    assign vec_rd    = r_vec[vec_ridx];

    always_comb begin
        case (r_axis)
            2'd0:    axis_x = r_item.accel_x;
            2'd1:    axis_x = r_item.accel_y;
            default: axis_x = r_item.accel_z;
        endcase
    end

    // one restoring division step, one quotient bit a cycle
    assign div    = (r_cfg.filter_divisor == 8'd0) ? 8'd1 : r_cfg.filter_divisor;
    assign div_t9 = {r_drem, r_dq[15]};
    assign div_ge = div_t9 >= {1'b0, div};

    assign f_diff    = {axis_x[15], axis_x} - {vec_rd[15], vec_rd};
    assign f_q       = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    assign f_ynew    = r_first ? {r_x[15], r_x} : ({r_y[15], r_y} + f_q);
    assign f_dev     = {r_x[15], r_x} - {f_ynew[15], f_ynew[15:0]};
    assign f_dev_mag = f_dev[16] ? 17'(-f_dev) : 17'(f_dev);

    assign s_diff = {r_tdat[15], r_tdat} - {r_vq[15], r_vq};
    assign s_mag  = s_diff[16] ? 16'(-s_diff) : s_diff[15:0];

    // one root digit a cycle
    assign q_rem   = {r_rem[15:0], r_sv[29:28]};
    assign q_trial = {1'b0, r_root, 2'b01};

    assign cand_dist = r_sat ? fgtm_pkg::DIST_MAX : r_root;
    assign cmp_l     = 19'(cand_dist) * 19'd5;
    assign cmp_r     = 19'(r_rad[14:0]) * 19'd6;
    assign hit       = !r_rad[15] && (cmp_l <= cmp_r) && (cand_dist < r_best);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fgtm_pkg::ST_IDLE:
                if (i_item_avail && i_res_space) n_state = fgtm_pkg::ST_EXEC;
            fgtm_pkg::ST_EXEC: begin
                if (r_item.command != fgtm_pkg::CMD_SAMPLE) n_state = fgtm_pkg::ST_DONE;
                else if (sensor_ok) n_state = fgtm_pkg::ST_F_START;
                else n_state = fgtm_pkg::ST_T_START;
            end
            fgtm_pkg::ST_F_START:
                n_state = r_first ? fgtm_pkg::ST_F_WR : fgtm_pkg::ST_F_DIV;
            fgtm_pkg::ST_F_DIV:
                if (r_it == 4'(fgtm_pkg::DIV_STEPS - 1)) n_state = fgtm_pkg::ST_F_WR;
            fgtm_pkg::ST_F_WR:
                n_state = (r_axis == 2'd2) ? fgtm_pkg::ST_T_START : fgtm_pkg::ST_F_START;
            fgtm_pkg::ST_T_START:
                n_state = (r_t >= r_n) ? fgtm_pkg::ST_DONE : fgtm_pkg::ST_T_ACC;
            fgtm_pkg::ST_T_ACC:
                if (r_ei == VCW'(VEC) && !r_p1 && !r_p2) n_state = fgtm_pkg::ST_T_SQRT;
            fgtm_pkg::ST_T_SQRT:
                if (r_sat || r_it == 4'(fgtm_pkg::SQRT_STEPS - 1)) n_state = fgtm_pkg::ST_T_CMP;
            fgtm_pkg::ST_T_CMP:
                n_state = fgtm_pkg::ST_T_START;
            fgtm_pkg::ST_DONE:
                n_state = fgtm_pkg::ST_IDLE;
            default:
                n_state = fgtm_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_item_pop = (r_state == fgtm_pkg::ST_IDLE) && i_item_avail && i_res_space;
        o_res_push = (r_state == fgtm_pkg::ST_DONE);
        o_res      = r_res;
    end

    // control state, configuration and filter vector
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fgtm_pkg::ST_IDLE;
            r_cfg   <= '{filter_divisor:   fgtm_pkg::RST_FILTER_DIVISOR,
                         stable_threshold: fgtm_pkg::RST_STABLE_THRESHOLD,
                         idle_reload:      fgtm_pkg::RST_IDLE_RELOAD,
                         template_count:   fgtm_pkg::RST_TEMPLATE_COUNT};
            r_first <= 1'b1;
            r_idle  <= 15'(INITIAL_IDLE_TICKS);
            for (int k = 0; k < VEC; k++) r_vec[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (fgtm_pkg::t_cfg_idx'(i_cfg_idx))
                    fgtm_pkg::CFG_FILTER_DIVISOR:   r_cfg.filter_divisor   <= i_cfg_data[7:0];
                    fgtm_pkg::CFG_STABLE_THRESHOLD: r_cfg.stable_threshold <= i_cfg_data;
                    fgtm_pkg::CFG_IDLE_RELOAD:      r_cfg.idle_reload      <= i_cfg_data[14:0];
                    fgtm_pkg::CFG_TEMPLATE_COUNT:   r_cfg.template_count   <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (r_state == fgtm_pkg::ST_EXEC && r_item.command == fgtm_pkg::CMD_TICK) begin
                r_first <= 1'b0;
                if (r_idle != 15'd0) r_idle <= r_idle - 15'd1;
            end
            if (r_state == fgtm_pkg::ST_F_WR) begin
                r_vec[r_fidx] <= f_ynew[15:0];
                if (f_dev_mag > {1'b0, r_cfg.stable_threshold}) r_idle <= r_cfg.idle_reload;
            end
        end
    end

    // template and radius stores
    always_ff @(posedge i_clk) begin
        if (r_state == fgtm_pkg::ST_EXEC && r_item.command == fgtm_pkg::CMD_LOAD_WORD
            && 9'(r_item.template_index) < 9'(TEMPLATES)
            && 6'(r_item.element_index) < 6'(VEC)) begin
            r_tmem[AW'(int'(r_item.template_index) * VEC + int'(r_item.element_index))]
                <= r_item.load_value;
        end
        if (r_state == fgtm_pkg::ST_T_ACC && r_ei != VCW'(VEC)) begin
            r_tdat <= r_tmem[r_base + AW'(r_ei)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == fgtm_pkg::ST_EXEC && r_item.command == fgtm_pkg::CMD_LOAD_RADIUS
            && 9'(r_item.template_index) < 9'(TEMPLATES)) begin
            r_rmem[TW'(r_item.template_index)] <= r_item.load_value;
        end
        if (r_state == fgtm_pkg::ST_T_START) r_rad <= r_rmem[r_t[TW-1:0]];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            fgtm_pkg::ST_IDLE: begin
                if (o_item_pop) r_item <= i_item;
            end
            fgtm_pkg::ST_EXEC: begin
                r_axis  <= 2'd0;
                r_fidx  <= VW'(int'(r_item.sensor_index) * 3);
                r_t     <= '0;
                r_base  <= '0;
                r_best  <= fgtm_pkg::NO_MATCH_LIMIT;
                r_valid <= 1'b0;
                r_bidx  <= '0;
                r_n     <= (9'(r_cfg.template_count) > 9'(TEMPLATES)) ? TCW'(TEMPLATES)
                                                                     : TCW'(r_cfg.template_count);
                r_res   <= '{match_valid:    1'b0,
                             match_index:    5'd0,
                             match_distance: 15'd0,
                             sleep_request:  (r_item.command == fgtm_pkg::CMD_TICK)
                                             && (r_idle == 15'd0)};
            end
            fgtm_pkg::ST_F_START: begin
                r_x    <= axis_x;
                r_y    <= vec_rd;
                r_neg  <= f_diff[16];
                r_dq   <= f_diff[16] ? 16'(-f_diff) : f_diff[15:0];
                r_drem <= '0;
                r_it   <= '0;
            end
            fgtm_pkg::ST_F_DIV: begin
                r_drem <= div_ge ? 8'(div_t9 - {1'b0, div}) : div_t9[7:0];
                r_dq   <= {r_dq[14:0], div_ge};
                r_it   <= r_it + 4'd1;
            end
            fgtm_pkg::ST_F_WR: begin
                r_axis <= r_axis + 2'd1;
                r_fidx <= r_fidx + VW'(1);
            end
            fgtm_pkg::ST_T_START: begin
                r_ei  <= '0;
                r_acc <= '0;
                r_p1  <= 1'b0;
                r_p2  <= 1'b0;
            end
            fgtm_pkg::ST_T_ACC: begin
                // issue a read, square the difference, then accumulate
                if (r_ei != VCW'(VEC)) begin
                    r_vq <= vec_rd;
                    r_ei <= r_ei + VCW'(1);
                    r_p1 <= 1'b1;
                end else begin
                    r_p1 <= 1'b0;
                end
                r_p2 <= r_p1;
                if (r_p1) r_sq <= s_mag * s_mag;
                if (r_p2) r_acc <= r_acc + ACC_W'(r_sq);
                r_sv   <= r_acc[29:0];
                r_sat  <= |r_acc[ACC_W-1:30];
                r_rem  <= '0;
                r_root <= '0;
                r_it   <= '0;
            end
            fgtm_pkg::ST_T_SQRT: begin
                if (q_rem >= q_trial) begin
                    r_rem  <= 17'(q_rem - q_trial);
                    r_root <= {r_root[13:0], 1'b1};
                end else begin
                    r_rem  <= q_rem[16:0];
                    r_root <= {r_root[13:0], 1'b0};
                end
                r_sv <= {r_sv[27:0], 2'b00};
                r_it <= r_it + 4'd1;
            end
            fgtm_pkg::ST_T_CMP: begin
                if (hit) begin
                    r_best  <= cand_dist;
                    r_valid <= 1'b1;
                    r_bidx  <= 5'(r_t);
                end
                r_t    <= r_t + TCW'(1);
                r_base <= r_base + AW'(VEC);
            end
            default: ;
        endcase
        if (r_state == fgtm_pkg::ST_T_START && r_t >= r_n
            && r_item.command == fgtm_pkg::CMD_SAMPLE) begin
            r_res.match_valid    <= r_valid;
            r_res.match_index    <= r_valid ? r_bidx : 5'd0;
            r_res.match_distance <= r_valid ? r_best : 15'd0;
        end
    end

endmodule

### src/filtered_gesture_template_matcher.sv
// Top level of the filtered gesture template matcher: queues and engine.
//
//  channel   | direction | handshake     | beat
//  ----------+-----------+---------------+-------------------------------------------
//  command   | in        | push/full     | command, sensor, axes, indexes, load value
//  result    | out       | empty/pop     | match valid/index/distance, sleep request
//  config    | in        | i_cfg_we      | register index and data, no wait
//
// A tick or load takes the engine through idle, exec and done; a sample also runs the
// filter divider on each axis (skipped on the first pass and for an absent sensor) and then
// a scan of the templates, whose square root ends early on a saturated distance. Each queue adds a register.
// The single template memory read port and the digit-serial square root set the scan length.
// Reset is synchronous, active low; template and radius stores are not cleared.
// Two-entry queues on each side let the writer and reader stall independently.
module filtered_gesture_template_matcher #(
    parameter int SENSORS            = 7,
    parameter int TEMPLATES          = 32,
    parameter int INITIAL_IDLE_TICKS = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fgtm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fgtm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_command,
    input  logic [2:0]                      i_sensor_index,
    input  logic signed [15:0]              i_accel_x,
    input  logic signed [15:0]              i_accel_y,
    input  logic signed [15:0]              i_accel_z,
    input  logic [4:0]                      i_template_index,
    input  logic [4:0]                      i_element_index,
    input  logic signed [15:0]              i_load_value,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_match_valid,
    output logic [4:0]                      o_match_index,
    output logic [14:0]                     o_match_distance,
    output logic                            o_sleep_request
);

    fgtm_pkg::t_item   in_item;
    fgtm_pkg::t_item   q_item;
    fgtm_pkg::t_result c_res;
    fgtm_pkg::t_result q_res;
    logic              iq_empty;
    logic              iq_pop;
    logic              oq_full;
    logic              oq_push;

    // pack the command beat
    always_comb begin
        in_item.command        = fgtm_pkg::t_cmd'(i_command);
        in_item.sensor_index   = i_sensor_index;
        in_item.accel_x        = i_accel_x;
        in_item.accel_y        = i_accel_y;
        in_item.accel_z        = i_accel_z;
        in_item.template_index = i_template_index;
        in_item.element_index  = i_element_index;
        in_item.load_value     = i_load_value;
    end

    fgtm_fifo #(.W($bits(fgtm_pkg::t_item))) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_din   (in_item),
        .o_full  (full),
        .i_rd    (iq_pop),
        .o_dout  (q_item),
        .o_empty (iq_empty)
    );

    fgtm_core #(
        .SENSORS            (SENSORS),
        .TEMPLATES          (TEMPLATES),
        .INITIAL_IDLE_TICKS (INITIAL_IDLE_TICKS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item       (q_item),
        .i_item_avail (!iq_empty),
        .o_item_pop   (iq_pop),
        .o_res        (c_res),
        .o_res_push   (oq_push),
        .i_res_space  (!oq_full)
    );

    fgtm_fifo #(.W($bits(fgtm_pkg::t_result))) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (oq_push),
        .i_din   (c_res),
        .o_full  (oq_full),
        .i_rd    (pop),
        .o_dout  (q_res),
        .o_empty (empty)
    );

    // unpack the result beat
    assign o_match_valid    = q_res.match_valid;
    assign o_match_index    = q_res.match_index;
    assign o_match_distance = q_res.match_distance;
    assign o_sleep_request  = q_res.sleep_request;

endmodule
